FILE: rtl/core/point_in_polygon_tester_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon tester
// Checks run in simulation and compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TESTER_DEFINES_SVH
`define POINT_IN_POLYGON_TESTER_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define PIP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define PIP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PIP_ASSERT(label, clk, rst, prop, msg)
`define PIP_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

FILE: rtl/core/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and defaults for the point-in-polygon tester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

   localparam int unsigned MAX_VERTICES_DEF = 64;
   localparam int unsigned COORD_WIDTH_DEF  = 32;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEST = 1'b1
   } pip_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_EDGE,
      ST_MUL,
      ST_FINISH
   } pip_state_type;

   // steps of the shared multiplier for one edge
   typedef enum logic [2:0] {
      MS_LO_L,
      MS_HI_L,
      MS_LO_R,
      MS_HI_R,
      MS_DRAIN,
      MS_DECIDE
   } pip_step_type;

endpackage

FILE: rtl/core/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_ram #(
   parameter  int unsigned WIDTH = 2 * pip_pkg::COORD_WIDTH_DEF,
   parameter  int unsigned DEPTH = pip_pkg::MAX_VERTICES_DEF,
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/point_in_polygon_tester.sv
// ----------------------------------------------------------------------------
// point_in_polygon_tester
// Crossing-number point-in-polygon test over a stored polygon. A load beat
// (opcode 0) writes vertex (x, y) into slot vertex_index and gives no result;
// a load to a slot at or above MAX_VERTICES is dropped. A test beat (opcode 1)
// walks the first vertex_count vertices (saturated at MAX_VERTICES) and
// returns one beat with inside_res = crossing parity. Coordinates are signed
// fixed point with 8 fraction bits; the crossing test is exact, done as a
// cross-multiplication compare on one shared multiplier. A load keeps the
// input ready. After a test is accepted the input stays not-ready while the
// block fetches the closing vertex, reads the vertex store once per edge,
// runs the shared multiplier steps for each edge whose endpoints straddle
// the point's y (two half-width products per side, one drain, one sign
// decision) and then takes the finish step; an empty polygon goes straight
// to the finish step. The finish step holds while the output register still
// carries an unaccepted result, and the input stays not-ready meanwhile.
// The result sits in an output register, so the next beat is accepted while
// a result still waits. Vertex slots are undefined until written; the store
// needs no clearing after reset. The user must write vertex_count through
// csr_wr_en / csr_wr_data only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_in_polygon_tester_defines.svh"

module point_in_polygon_tester #(
   parameter  int unsigned MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
   parameter  int unsigned COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
   localparam int unsigned AW           = $clog2(MAX_VERTICES),
   localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1),
   localparam int unsigned DW           = COORD_WIDTH + 1,
   localparam int unsigned LW           = (DW + 1) / 2,
   localparam int unsigned HW           = DW - LW,
   localparam int unsigned MW           = DW + LW + 1,
   localparam int unsigned PW           = 2 * DW
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [AW-1:0]                 req_vertex_index,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_inside_res,
   // vertex count register
   input  logic                          csr_wr_en,
   input  logic [CNT_W-1:0]              csr_wr_data
);

   // ------------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------------
   pip_pkg::pip_state_type state_ff, state_in;
   pip_pkg::pip_step_type  step_ff,  step_in;

   logic [CNT_W-1:0] count_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_inside_ff, rsp_inside_in;
   logic             parity_ff, parity_in;
   logic             last_ff, last_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    last_idx_ff, last_idx_in;

   logic signed [COORD_WIDTH-1:0] tx_ff, tx_in;
   logic signed [COORD_WIDTH-1:0] ty_ff, ty_in;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_WIDTH-1:0] prev_y_ff, prev_y_in;

   // operands: left product d1*d2, right product d3*d4
   logic signed [DW-1:0] d1_ff, d1_in;
   logic signed [DW-1:0] d2_ff, d2_in;
   logic signed [DW-1:0] d3_ff, d3_in;
   logic signed [DW-1:0] d4_ff, d4_in;
   logic signed [PW-1:0] pp_ff, pp_in;
   logic signed [PW-1:0] acc_ff, acc_in;

   logic [CNT_W-1:0] n_sat;
   logic [CNT_W-1:0] n_m1;
   logic [AW:0]      idx_ext;
   logic             idx_ok;
   logic             req_fire;
   logic             test_fire;
   logic             ram_wr_en;

   logic [2*COORD_WIDTH-1:0]      ram_rd_data;
   logic signed [COORD_WIDTH-1:0] cur_x;
   logic signed [COORD_WIDTH-1:0] cur_y;
   logic                          above_cur;
   logic                          above_prev;
   logic                          straddle;
   logic                          edge_last;
   logic signed [COORD_WIDTH-1:0] xa, ya, xb, yb;

   logic                 step_left;
   logic                 step_hi;
   logic signed [DW-1:0] mul_a;
   logic signed [DW-1:0] mul_b;
   logic signed [LW:0]   mul_chunk;
   logic signed [MW-1:0] mul_prod;
   logic signed [PW-1:0] pp_shift;

   // ------------------------------------------------------------------------
   // Vertex store: x in the upper half, y in the lower half of each word.
   // Read data always reflects the slot held in addr_ff.
   // ------------------------------------------------------------------------
   assign req_fire  = req_valid && req_ready;
   assign test_fire = req_fire && (req_opcode == pip_pkg::OP_TEST);
   assign idx_ext   = {1'b0, req_vertex_index};
   assign idx_ok    = idx_ext < (AW + 1)'(MAX_VERTICES);
   assign ram_wr_en = req_fire && (req_opcode == pip_pkg::OP_LOAD) && idx_ok;

   pip_ram #(
      .WIDTH (2 * COORD_WIDTH),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_vertex_index),
      .wr_data ({req_x_coord, req_y_coord}),
      .rd_addr (addr_in),
      .rd_data (ram_rd_data)
   );

   assign cur_x = $signed(ram_rd_data[2*COORD_WIDTH-1:COORD_WIDTH]);
   assign cur_y = $signed(ram_rd_data[COORD_WIDTH-1:0]);

   // Saturate the vertex count to the store depth.
   assign n_sat = (count_ff > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_ff;
   assign n_m1  = n_sat - CNT_W'(1);

   // ------------------------------------------------------------------------
   // Edge setup: current vertex i against previous vertex j = i-1 (cyclic).
   // Orient the edge from its lower endpoint a to its upper endpoint b.
   // ------------------------------------------------------------------------
   assign above_cur  = cur_y > ty_ff;
   assign above_prev = prev_y_ff > ty_ff;
   assign straddle   = above_cur ^ above_prev;
   assign edge_last  = addr_ff == last_idx_ff;

   assign xa = above_cur ? prev_x_ff : cur_x;
   assign ya = above_cur ? prev_y_ff : cur_y;
   assign xb = above_cur ? cur_x : prev_x_ff;
   assign yb = above_cur ? cur_y : prev_y_ff;

   // ------------------------------------------------------------------------
   // Shared multiplier: full operand times one half of the other operand.
   // Low half is unsigned, high half carries the sign; acc = left - right.
   // ------------------------------------------------------------------------
   assign step_left = (step_ff == pip_pkg::MS_LO_L) || (step_ff == pip_pkg::MS_HI_L);
   assign step_hi   = (step_ff == pip_pkg::MS_HI_L) || (step_ff == pip_pkg::MS_HI_R);
   assign mul_a     = step_left ? d1_ff : d3_ff;
   assign mul_b     = step_left ? d2_ff : d4_ff;
   assign mul_chunk = step_hi ? $signed({{(LW + 1 - HW){mul_b[DW-1]}}, mul_b[DW-1:LW]})
                              : $signed({1'b0, mul_b[LW-1:0]});
   assign mul_prod  = mul_a * mul_chunk;
   assign pp_shift  = pp_ff <<< LW;

   // ------------------------------------------------------------------------
   // Sequencer: next state and datapath updates
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_inside_in = rsp_inside_ff;
      parity_in     = parity_ff;
      last_in       = last_ff;
      addr_in       = addr_ff;
      last_idx_in   = last_idx_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      d3_in         = d3_ff;
      d4_in         = d4_ff;
      pp_in         = $signed({{(PW - MW){mul_prod[MW-1]}}, mul_prod});
      acc_in        = acc_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (test_fire) begin
               tx_in       = req_x_coord;
               ty_in       = req_y_coord;
               parity_in   = 1'b0;
               last_idx_in = n_m1[AW-1:0];
               // start the walk at the closing vertex n-1
               addr_in     = n_m1[AW-1:0];
               if (n_sat == '0) begin
                  state_in = pip_pkg::ST_FINISH;
               end else begin
                  state_in = pip_pkg::ST_FIRST;
               end
            end
         end

         pip_pkg::ST_FIRST: begin
            prev_x_in = cur_x;
            prev_y_in = cur_y;
            addr_in   = '0;
            state_in  = pip_pkg::ST_EDGE;
         end

         pip_pkg::ST_EDGE: begin
            prev_x_in = cur_x;
            prev_y_in = cur_y;
            addr_in   = addr_ff + AW'(1);
            last_in   = edge_last;
            d1_in     = $signed({tx_ff[COORD_WIDTH-1], tx_ff}) - $signed({xa[COORD_WIDTH-1], xa});
            d2_in     = $signed({yb[COORD_WIDTH-1], yb}) - $signed({ya[COORD_WIDTH-1], ya});
            d3_in     = $signed({xb[COORD_WIDTH-1], xb}) - $signed({xa[COORD_WIDTH-1], xa});
            d4_in     = $signed({ty_ff[COORD_WIDTH-1], ty_ff}) - $signed({ya[COORD_WIDTH-1], ya});
            if (straddle) begin
               step_in  = pip_pkg::MS_LO_L;
               state_in = pip_pkg::ST_MUL;
            end else if (edge_last) begin
               state_in = pip_pkg::ST_FINISH;
            end
         end

         pip_pkg::ST_MUL: begin
            // clear acc in the first step, then accumulate the partial product of the previous step
            unique case (step_ff)
               pip_pkg::MS_LO_L: begin
                  acc_in  = '0;
                  step_in = pip_pkg::MS_HI_L;
               end
               pip_pkg::MS_HI_L: begin
                  acc_in  = acc_ff + pp_ff;
                  step_in = pip_pkg::MS_LO_R;
               end
               pip_pkg::MS_LO_R: begin
                  acc_in  = acc_ff + pp_shift;
                  step_in = pip_pkg::MS_HI_R;
               end
               pip_pkg::MS_HI_R: begin
                  acc_in  = acc_ff - pp_ff;
                  step_in = pip_pkg::MS_DRAIN;
               end
               pip_pkg::MS_DRAIN: begin
                  acc_in  = acc_ff - pp_shift;
                  step_in = pip_pkg::MS_DECIDE;
               end
               pip_pkg::MS_DECIDE: begin
                  // left product below right product: crossing lies right
                  parity_in = parity_ff ^ acc_ff[PW-1];
                  if (last_ff) begin
                     state_in = pip_pkg::ST_FINISH;
                  end else begin
                     state_in = pip_pkg::ST_EDGE;
                  end
               end
               default: begin
                  step_in = pip_pkg::MS_LO_L;
               end
            endcase
         end

         pip_pkg::ST_FINISH: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = parity_ff;
               state_in      = pip_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pip_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pip_pkg::ST_IDLE;
         step_ff      <= pip_pkg::MS_LO_L;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
      parity_ff     <= parity_in;
      last_ff       <= last_in;
      addr_ff       <= addr_in;
      last_idx_ff   <= last_idx_in;
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      d1_ff         <= d1_in;
      d2_ff         <= d2_in;
      d3_ff         <= d3_in;
      d4_ff         <= d4_in;
      pp_ff         <= pp_in;
      acc_ff        <= acc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `PIP_ASSERT(a_test_starts_walk, clock, reset, (test_fire && (n_sat != '0)) |=> (state_ff == pip_pkg::ST_FIRST), "test with vertices did not start the edge walk")
   `PIP_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == pip_pkg::ST_FINISH), "result raised outside the finish step")
   `PIP_ASSERT_NEVER(a_addr_in_range, clock, reset, (state_ff == pip_pkg::ST_EDGE) && (addr_ff > last_idx_ff), "edge walk read beyond the vertex count")
   `PIP_ASSERT(a_skip_flat_edge, clock, reset, ((state_ff == pip_pkg::ST_EDGE) && !straddle) |=> (state_ff != pip_pkg::ST_MUL), "non-straddling edge sent to the multiplier")

endmodule
